// File: rtl/cwt_pkg.sv
// cwt_pkg: types and constants shared by the code watch table.
// Depends on nothing; imported by code_watch_table.
package cwt_pkg;

   localparam int CODE_W  = 12;   // four octal digits
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 5;    // width of the reported entry count

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_FETCH,
      S_DONE
   } state_type;

endpackage

// File: rtl/code_watch_table.sv
// code_watch_table: packed table of 12-bit octal codes with add, remove,
// lookup and read requests. Depends on cwt_pkg.
//
// The block holds up to DEPTH codes, packed from position 0, in a single
// synchronous memory (one read and one write port, registered read data).
// One request is handled at a time. After acceptance a request is checked
// in S_EXEC, then walks the memory one entry per cycle:
//   add / lookup : scan of the held entries, stopping at the first match;
//                  an add that finds no match writes in the last scan cycle;
//   remove       : shift of the entries above index;
//   read         : one memory read.
// S_DONE then places the response in the output register once that is free;
// the walk is paced by the memory read port, which yields one entry per
// cycle. The next request can be taken as soon as the previous response
// sits in the output register, even if the receiver still stalls it.
// The table needs no clearing after reset: only entries below the count
// are ever read.
module code_watch_table #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [cwt_pkg::CODE_W-1:0]      req_code,
   input  logic [cwt_pkg::INDEX_W-1:0]     req_index,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_found,
   output logic [cwt_pkg::CODE_W-1:0]      rsp_code_out,
   output logic [cwt_pkg::COUNT_W-1:0]     rsp_entry_count
);
   import cwt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // memory address
   localparam int CW = $clog2(DEPTH + 1);                 // holds 0..DEPTH

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;       // next entry to read
   logic                   pend_ff, pend_in;     // read data due this cycle
   logic [AW-1:0]          raddr_ff, raddr_in;   // address behind rd_data_ff

   // latched request
   mode_type               mode_ff, mode_in;
   logic [CODE_W-1:0]      code_ff, code_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;

   // staged result, waiting for the output register
   status_type             res_status_ff, res_status_in;
   logic                   res_found_ff, res_found_in;
   logic [CODE_W-1:0]      res_code_ff, res_code_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [CODE_W-1:0]      rsp_code_ff, rsp_code_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------------
   // Code memory
   // ---------------------------------------------------------------------
   logic [CODE_W-1:0]      code_mem [DEPTH];
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [CODE_W-1:0]      rd_data_ff;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [CODE_W-1:0]      wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= code_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic                   accept;
   logic                   out_free;
   logic                   issue;
   logic                   hit;
   logic [INDEX_W-1:0]     count_wide;
   logic [7:0]             count_rep;

   // requests are taken only while idle
   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_wide = INDEX_W'(count_ff);
   assign count_rep  = 8'(count_ff);
   assign hit        = pend_ff && (rd_data_ff == code_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      raddr_in      = raddr_ff;
      mode_in       = mode_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_code_in   = res_code_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = code_ff;
      issue         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = mode_type'(req_mode);
               code_in  = req_code;
               idx_in   = req_index;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_status_in = STAT_DONE;
            res_found_in  = 1'b0;
            res_code_in   = '0;
            ptr_in        = '0;
            unique case (mode_ff)
               MODE_ADD: begin
                  // fullness is tested before the duplicate scan
                  if (count_ff >= CW'(DEPTH)) begin
                     res_status_in = STAT_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               MODE_LOOKUP: begin
                  state_in = S_SCAN;
               end
               MODE_REMOVE: begin
                  if (idx_ff >= count_wide) begin
                     res_status_in = STAT_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     ptr_in   = CW'(idx_ff) + CW'(1);
                     state_in = S_SHIFT;
                  end
               end
               MODE_READ: begin
                  if (idx_ff >= count_wide) begin
                     res_status_in = STAT_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_ff[AW-1:0];
                     state_in = S_FETCH;
                  end
               end
            endcase
         end

         // Pipelined search: issue one read per cycle, compare its data in the cycle after.
         S_SCAN: begin
            issue = (ptr_ff < count_ff) && !hit;
            if (hit) begin
               if (mode_ff == MODE_ADD) begin
                  res_status_in = STAT_DUP;
               end else begin
                  res_found_in = 1'b1;
               end
               state_in = S_DONE;
            end else if (!issue && !pend_ff) begin
               if (mode_ff == MODE_ADD) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               state_in = S_DONE;
            end else begin
               rd_en   = issue;
               pend_in = issue;
               if (issue) begin
                  ptr_in = ptr_ff + CW'(1);
               end
            end
         end

         // Shift down: read entry i+1, write it back at i the next cycle.
         S_SHIFT: begin
            issue = ptr_ff < count_ff;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = raddr_ff - AW'(1);
               wr_data = rd_data_ff;
            end
            if (issue) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               raddr_in = ptr_ff[AW-1:0];
               ptr_in   = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end

         S_FETCH: begin
            res_code_in = rd_data_ff;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_code_in   = res_code_ff;
               rsp_count_in  = count_rep[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      raddr_ff      <= raddr_in;
      mode_ff       <= mode_in;
      code_ff       <= code_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_code_ff   <= res_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_code_out    = rsp_code_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
